/* rtl/core/dpw_pkg.sv */
// ----------------------------------------------------------------------------
// dpw_pkg: shared types, constants and helpers
// Fixed-point formats, register map, saturating add and output rounding for
// the depth pixel to world point pipeline.
// ----------------------------------------------------------------------------
package dpw_pkg;

  localparam int COORD_BITS = 11;
  localparam int DEPTH_BITS = 16;
  localparam int LEFT_START = 50;

  // internal values are saturated to +-(2^62 - 1), so 63 bits signed
  localparam int QW = 63;
  typedef logic signed [QW-1:0] q_t;

  localparam q_t LIM      = q_t'(63'h3FFF_FFFF_FFFF_FFFF);
  localparam q_t ONE_Q30  = q_t'(63'd1073741824);
  localparam q_t TILT_COS = q_t'(63'd1008987269);
  localparam q_t TILT_SIN = q_t'(63'd367241333);
  localparam q_t CAM_Z    = q_t'(63'd4587520);   // 70 cm, Q16
  localparam q_t Z_HIGH   = q_t'(63'd9830400);   // 150 cm, Q16
  localparam q_t Z_LOW    = -q_t'(63'd3276800);  // -50 cm, Q16

  // product shifts
  localparam logic [5:0] SH_RAY = 6'd18;
  localparam logic [5:0] SH_Q30 = 6'd30;
  localparam logic [5:0] SH_CAM = 6'd38;

  // multiplier pipeline depth and overall request latency (accept edge to
  // the edge that captures done)
  localparam int MUL_LAT = 4;
  localparam int LAT     = 9 * MUL_LAT + 9;

  // register map, 64-bit registers at 8-byte spacing
  localparam int NREG   = 8;
  localparam int IDX_W  = 3;
  localparam int ADDR_W = IDX_W + 3;

  typedef enum logic [IDX_W-1:0] {
    REG_PP     = 3'd0,
    REG_IFOC   = 3'd1,
    REG_K12    = 3'd2,
    REG_P12    = 3'd3,
    REG_K3EN   = 3'd4,
    REG_PAN    = 3'd5,
    REG_DSCALE = 3'd6,
    REG_ORG    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [31:0]        ppx;
    logic [31:0]        ppy;
    logic [31:0]        ifx;
    logic [31:0]        ify;
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    logic signed [31:0] k3;
    logic               dist_en;
    logic signed [31:0] pan_c;
    logic signed [31:0] pan_s;
    logic [31:0]        scale;
    logic signed [31:0] org_x;
    logic signed [31:0] org_y;
  } cfg_t;

  typedef struct packed {
    logic vld;
    logic hd;
    logic col_ok;
  } flag_t;

  function automatic logic [63:0] reg_reset(reg_idx_t idx);
    logic [63:0] v;
    begin
      case (idx)
        REG_PAN:    v = 64'h4000_0000_0000_0000;
        REG_DSCALE: v = 64'd1677722;
        default:    v = 64'd0;
      endcase
      return v;
    end
  endfunction

  function automatic q_t sadd(q_t a, q_t b);
    logic signed [QW:0] s;
    begin
      s = {a[QW-1], a} + {b[QW-1], b};
      if (s > LIM) return LIM;
      else if (s < -LIM) return -LIM;
      else return s[QW-1:0];
    end
  endfunction

  // Q16 -> 1/256 units, round half away from zero, saturate to 32 bits
  function automatic logic signed [31:0] out32(q_t v);
    logic [QW-2:0] mag;
    logic [QW-1:0] r;
    begin
      mag = v[QW-1] ? (QW-1)'(-v) : (QW-1)'(v);
      r   = ({1'b0, mag} + 63'd128) >> 8;
      if (!v[QW-1]) begin
        return (r > 63'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(r[31:0]);
      end else begin
        return (r > 63'h8000_0000) ? 32'sh8000_0000 : -signed'(r[31:0]);
      end
    end
  endfunction

endpackage

/* rtl/core/depth_pixel_to_world_point_top.sv */
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point_top: depth pixel to world point pipeline
// Deprojects a depth pixel, optionally undistorts, tilts, pans and offsets it.
// ----------------------------------------------------------------------------
// Usage: one request (column, row, depth_sample) may be issued every cycle
// with start; busy is high only during reset. Each request gives exactly one
// result, marked by done for one cycle. A request passes through the input
// stage, nine multiplier passes of 4 stages each, the adder stages and the
// output stage, which registers done together with the result. The
// result side has no back-pressure: capture on done. Outside reset, throughput
// is one request per clock, set by the fully pipelined multipliers.
// Configuration goes through the APB port (64-bit data, register i at byte
// 8*i) and must only change while no request is in flight.
module depth_pixel_to_world_point_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dpw_pkg::ADDR_W-1:0]     paddr,
  input  logic [63:0]                    pwdata,
  output logic [63:0]                    prdata,
  output logic                           pready,
  input  logic                           start,
  output logic                           busy,
  input  logic [dpw_pkg::COORD_BITS-1:0] column,
  input  logic [dpw_pkg::COORD_BITS-1:0] row,
  input  logic [dpw_pkg::DEPTH_BITS-1:0] depth_sample,
  output logic                           done,
  output logic signed [31:0]             world_x,
  output logic signed [31:0]             world_y,
  output logic signed [31:0]             world_z,
  output logic                           has_depth,
  output logic                           accepted
);
  import dpw_pkg::*;

  localparam int L   = MUL_LAT;
  localparam int DW  = DEPTH_BITS + 32;
  // delay line lengths, derived from the stage schedule
  localparam int NXD = 5 * L + 4;   // ray x/y to undistort and camera stages
  localparam int NTD = 3 * L + 1;   // tangential terms
  localparam int NDD = 6 * L + 3;   // depth to camera stage
  localparam int NZL = 8 * L + 4;   // forward distance to pan stage
  localparam int NFL = 9 * L + 7;   // flags to output stage

  cfg_t cfg;

  dpw_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign busy = rst;

  // ---- input stage ----
  logic [COORD_BITS-1:0] col0, row0;
  logic [DEPTH_BITS-1:0] raw0;
  flag_t                 flag0;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag0 <= '0;
    end else begin
      flag0.vld    <= start;
      flag0.hd     <= depth_sample != '0;
      flag0.col_ok <= column >= COORD_BITS'(LEFT_START);
    end
    col0 <= column;
    row0 <= row;
    raw0 <= depth_sample;
  end

  // pixel offset from principal point, Q16
  q_t dx0, dy0, ifx_q, ify_q;
  assign dx0   = q_t'($signed({1'b0, col0, 16'd0})) - q_t'($signed({1'b0, cfg.ppx}));
  assign dy0   = q_t'($signed({1'b0, row0, 16'd0})) - q_t'($signed({1'b0, cfg.ppy}));
  assign ifx_q = q_t'({1'b0, cfg.ifx});
  assign ify_q = q_t'({1'b0, cfg.ify});

  q_t k1q, k2q, k3q, p1q, p2q, pcq, psq, oxq, oyq;
  assign k1q = q_t'(cfg.k1);
  assign k2q = q_t'(cfg.k2);
  assign k3q = q_t'(cfg.k3);
  assign p1q = q_t'(cfg.p1);
  assign p2q = q_t'(cfg.p2);
  assign pcq = q_t'(cfg.pan_c);
  assign psq = q_t'(cfg.pan_s);
  assign oxq = q_t'(cfg.org_x);
  assign oyq = q_t'(cfg.org_y);

  // ---- normalized ray, Q30 ----
  q_t x_r, y_r;
  dpw_mul u_mx (.clk, .a(dx0), .b(ifx_q), .sh(SH_RAY), .p(x_r));
  dpw_mul u_my (.clk, .a(dy0), .b(ify_q), .sh(SH_RAY), .p(y_r));

  // ---- depth in cm (Q24) and forward distance (Q16) ----
  logic [DW-1:0] d1;
  logic [DW-1:0] dd [NDD];
  q_t            zl [NZL];

  always_ff @(posedge clk) begin
    d1    <= raw0 * cfg.scale;
    dd[0] <= d1;
    for (int k = 1; k < NDD; k++) dd[k] <= dd[k-1];
    zl[0] <= q_t'((d1 + DW'(128)) >> 8);
    for (int k = 1; k < NZL; k++) zl[k] <= zl[k-1];
  end

  // ---- inverse distortion ----
  q_t xd [NXD];
  q_t yd [NXD];
  q_t xx_r, yy_r, xy_r, r2_r, xx2_r, yy2_r, sx_r, sy_r;
  q_t r4_r, k1r2_r, r6_r, k2r4_r, k3r6_r, f1_r, f2_r, f_r;
  q_t t1_r, t2_r, tx_r, tyy_r, qx_r, qy_r, xf_r, yf_r;
  q_t ua_r, va_r, ux_r, uy_r;
  q_t r2d [L];
  q_t f1d [L-1];
  q_t f2d [L-1];
  q_t txd [NTD];
  q_t tyd [NTD];
  q_t qxd [NTD];
  q_t qyd [NTD];

  dpw_mul u_mxx  (.clk, .a(x_r),  .b(x_r),  .sh(SH_Q30), .p(xx_r));
  dpw_mul u_myy  (.clk, .a(y_r),  .b(y_r),  .sh(SH_Q30), .p(yy_r));
  dpw_mul u_mxy  (.clk, .a(x_r),  .b(y_r),  .sh(SH_Q30), .p(xy_r));
  dpw_mul u_mr4  (.clk, .a(r2_r), .b(r2_r), .sh(SH_Q30), .p(r4_r));
  dpw_mul u_mk1  (.clk, .a(k1q),  .b(r2_r), .sh(SH_Q30), .p(k1r2_r));
  dpw_mul u_mr6  (.clk, .a(r4_r), .b(r2d[L-1]), .sh(SH_Q30), .p(r6_r));
  dpw_mul u_mk2  (.clk, .a(k2q),  .b(r4_r), .sh(SH_Q30), .p(k2r4_r));
  dpw_mul u_mk3  (.clk, .a(k3q),  .b(r6_r), .sh(SH_Q30), .p(k3r6_r));
  dpw_mul u_mt1  (.clk, .a(p1q),  .b(xy_r), .sh(SH_Q30), .p(t1_r));
  dpw_mul u_mt2  (.clk, .a(p2q),  .b(xy_r), .sh(SH_Q30), .p(t2_r));
  dpw_mul u_mqx  (.clk, .a(p2q),  .b(sx_r), .sh(SH_Q30), .p(qx_r));
  dpw_mul u_mqy  (.clk, .a(p1q),  .b(sy_r), .sh(SH_Q30), .p(qy_r));
  dpw_mul u_mxf  (.clk, .a(xd[4*L+1]), .b(f_r), .sh(SH_Q30), .p(xf_r));
  dpw_mul u_myf  (.clk, .a(yd[4*L+1]), .b(f_r), .sh(SH_Q30), .p(yf_r));

  always_ff @(posedge clk) begin
    xd[0] <= x_r;
    yd[0] <= y_r;
    for (int k = 1; k < NXD; k++) begin
      xd[k] <= xd[k-1];
      yd[k] <= yd[k-1];
    end
    r2_r  <= sadd(xx_r, yy_r);
    xx2_r <= sadd(xx_r, xx_r);
    yy2_r <= sadd(yy_r, yy_r);
    sx_r  <= sadd(r2_r, xx2_r);
    sy_r  <= sadd(r2_r, yy2_r);
    r2d[0] <= r2_r;
    for (int k = 1; k < L; k++) r2d[k] <= r2d[k-1];
    // radial factor f = 1 + k1 r2 + k2 r4 + k3 r6
    f1_r  <= sadd(ONE_Q30, k1r2_r);
    f1d[0] <= f1_r;
    for (int k = 1; k < L - 1; k++) f1d[k] <= f1d[k-1];
    f2_r  <= sadd(f1d[L-2], k2r4_r);
    f2d[0] <= f2_r;
    for (int k = 1; k < L - 1; k++) f2d[k] <= f2d[k-1];
    f_r   <= sadd(f2d[L-2], k3r6_r);
    // tangential terms
    tx_r  <= sadd(t1_r, t1_r);
    tyy_r <= sadd(t2_r, t2_r);
    txd[0] <= tx_r;
    tyd[0] <= tyy_r;
    qxd[0] <= qx_r;
    qyd[0] <= qy_r;
    for (int k = 1; k < NTD; k++) begin
      txd[k] <= txd[k-1];
      tyd[k] <= tyd[k-1];
      qxd[k] <= qxd[k-1];
      qyd[k] <= qyd[k-1];
    end
    ua_r <= sadd(xf_r, txd[NTD-1]);
    va_r <= sadd(yf_r, tyd[NTD-1]);
    ux_r <= sadd(ua_r, qxd[NTD-1]);
    uy_r <= sadd(va_r, qyd[NTD-1]);
  end

  // ---- camera point ----
  q_t xs, ys, dq, xc_r, yc_r, wy, wz;
  assign xs = cfg.dist_en ? ux_r : xd[NXD-1];
  assign ys = cfg.dist_en ? uy_r : yd[NXD-1];
  assign dq = q_t'(dd[NDD-1]);

  dpw_mul u_mxc (.clk, .a(xs), .b(dq), .sh(SH_CAM), .p(xc_r));
  dpw_mul u_myc (.clk, .a(ys), .b(dq), .sh(SH_CAM), .p(yc_r));

  // axis remap: world y = -Xc, world z = -Yc
  assign wy = -xc_r;
  assign wz = -yc_r;

  // ---- fixed tilt about x ----
  q_t m_yc, m_zs, m_ys, m_zc, ty_r, tz_r;
  dpw_mul u_myco (.clk, .a(wy), .b(TILT_COS), .sh(SH_Q30), .p(m_yc));
  dpw_mul u_mzsi (.clk, .a(wz), .b(TILT_SIN), .sh(SH_Q30), .p(m_zs));
  dpw_mul u_mysi (.clk, .a(wy), .b(TILT_SIN), .sh(SH_Q30), .p(m_ys));
  dpw_mul u_mzco (.clk, .a(wz), .b(TILT_COS), .sh(SH_Q30), .p(m_zc));

  // ---- pan about z ----
  q_t wx, m_xc, m_ts, m_xs, m_tc, px_r, py_r;
  q_t tzd [L+1];
  assign wx = zl[NZL-1];
  dpw_mul u_mpxc (.clk, .a(wx),   .b(pcq), .sh(SH_Q30), .p(m_xc));
  dpw_mul u_mpts (.clk, .a(ty_r), .b(psq), .sh(SH_Q30), .p(m_ts));
  dpw_mul u_mpxs (.clk, .a(wx),   .b(psq), .sh(SH_Q30), .p(m_xs));
  dpw_mul u_mptc (.clk, .a(ty_r), .b(pcq), .sh(SH_Q30), .p(m_tc));

  q_t pxo_r, pyo_r, tzo_r;
  flag_t fl [NFL];

  always_ff @(posedge clk) begin
    ty_r <= sadd(m_yc, m_zs);
    tz_r <= sadd(-m_ys, m_zc);
    tzd[0] <= tz_r;
    for (int k = 1; k <= L; k++) tzd[k] <= tzd[k-1];
    px_r <= sadd(m_xc, -m_ts);
    py_r <= sadd(m_xs, m_tc);
    // camera origin
    pxo_r <= sadd(px_r, oxq);
    pyo_r <= sadd(py_r, oyq);
    tzo_r <= sadd(tzd[L], CAM_Z);
  end

  // request flags ride along with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NFL; k++) fl[k] <= '0;
    end else begin
      fl[0] <= flag0;
      for (int k = 1; k < NFL; k++) fl[k] <= fl[k-1];
    end
  end

  // ---- output stage ----
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fl[NFL-1].vld;
    end
    has_depth <= fl[NFL-1].hd;
    if (fl[NFL-1].hd) begin
      world_x <= out32(pxo_r);
      world_y <= out32(pyo_r);
      world_z <= out32(tzo_r);
    end else begin
      world_x <= '0;
      world_y <= '0;
      world_z <= '0;
    end
    accepted <= fl[NFL-1].hd && fl[NFL-1].col_ok && (cfg.scale != '0)
                && (tzo_r < Z_HIGH) && (tzo_r > Z_LOW);
  end

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("request result missing at fixed latency");

  a_nodepth: assert property (@(posedge clk) disable iff (rst)
    (done && !has_depth) |-> (world_x == 0 && world_y == 0 && world_z == 0 && !accepted))
    else $error("no-depth result not zeroed");

  a_acc: assert property (@(posedge clk) disable iff (rst)
    (done && accepted) |-> has_depth)
    else $error("accepted without depth");
`endif

endmodule

/* rtl/core/dpw_mul.sv */
// ----------------------------------------------------------------------------
// dpw_mul: pipelined saturating fixed-point multiplier
// round(a*b / 2^sh) half away from zero, saturated to +-(2^62-1).
// Sign/magnitude split, four 31x31 partial products, sum, shift. 4 stages.
// ----------------------------------------------------------------------------
module dpw_mul (
  input  logic          clk,
  input  dpw_pkg::q_t   a,
  input  dpw_pkg::q_t   b,
  input  logic [5:0]    sh,
  output dpw_pkg::q_t   p
);
  import dpw_pkg::*;

  localparam int MW = QW - 1;
  localparam int HW = MW / 2;
  localparam int PW = 2 * MW + 1;

  logic [MW-1:0]   ua, ub;
  logic            neg1, neg2, neg3;
  logic [2*HW-1:0] pll, plh, phl, phh;
  logic [PW-1:0]   rnd, quo;
  logic [MW-1:0]   mag;

  always_comb begin
    quo = rnd >> sh;
    mag = (quo > PW'(LIM)) ? MW'(LIM) : quo[MW-1:0];
  end

  always_ff @(posedge clk) begin
    // stage 1: magnitudes
    ua   <= a[QW-1] ? MW'(-a) : MW'(a);
    ub   <= b[QW-1] ? MW'(-b) : MW'(b);
    neg1 <= a[QW-1] ^ b[QW-1];
    // stage 2: partial products
    pll  <= ua[HW-1:0] * ub[HW-1:0];
    plh  <= ua[HW-1:0] * ub[MW-1:HW];
    phl  <= ua[MW-1:HW] * ub[HW-1:0];
    phh  <= ua[MW-1:HW] * ub[MW-1:HW];
    neg2 <= neg1;
    // stage 3: full product plus rounding constant
    rnd  <= (PW'(phh) << (2*HW)) + (PW'(plh) << HW) + (PW'(phl) << HW) + PW'(pll)
            + (PW'(1) << (sh - 6'd1));
    neg3 <= neg2;
    // stage 4: shift, saturate, sign
    p    <= neg3 ? -q_t'({1'b0, mag}) : q_t'({1'b0, mag});
  end

endmodule

/* rtl/core/dpw_cfg.sv */
// ----------------------------------------------------------------------------
// dpw_cfg: APB configuration registers
// Eight 64-bit registers at 8-byte spacing; zero-wait writes and reads.
// ----------------------------------------------------------------------------
module dpw_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dpw_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready,
  output dpw_pkg::cfg_t              cfg
);
  import dpw_pkg::*;

  logic [63:0] regs [NREG];
  reg_idx_t    idx;
  logic [63:0] wval;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign pready = 1'b1;
  assign prdata = regs[idx];

  always_comb begin
    case (idx)
      REG_K3EN:   wval = {31'd0, pwdata[32:0]};
      REG_DSCALE: wval = {32'd0, pwdata[31:0]};
      default:    wval = pwdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREG; i++) regs[i] <= reg_reset(reg_idx_t'(IDX_W'(i)));
    end else if (psel && penable && pwrite) begin
      regs[idx] <= wval;
    end
  end

  always_comb begin
    cfg.ppx     = regs[REG_PP][63:32];
    cfg.ppy     = regs[REG_PP][31:0];
    cfg.ifx     = regs[REG_IFOC][63:32];
    cfg.ify     = regs[REG_IFOC][31:0];
    cfg.k1      = regs[REG_K12][63:32];
    cfg.k2      = regs[REG_K12][31:0];
    cfg.p1      = regs[REG_P12][63:32];
    cfg.p2      = regs[REG_P12][31:0];
    cfg.k3      = regs[REG_K3EN][31:0];
    cfg.dist_en = regs[REG_K3EN][32];
    cfg.pan_c   = regs[REG_PAN][63:32];
    cfg.pan_s   = regs[REG_PAN][31:0];
    cfg.scale   = regs[REG_DSCALE][31:0];
    cfg.org_x   = regs[REG_ORG][63:32];
    cfg.org_y   = regs[REG_ORG][31:0];
  end

endmodule

/* verif/depth_pixel_to_world_point_top_tb.sv */
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point_top_tb: self-checking bench for the world point
// pipeline. Drives pixel requests with random gaps and programs the registers
// over APB between phases. A bit-exact model predicts each point, and every
// done strobe is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module depth_pixel_to_world_point_top_tb;
  import dpw_pkg::*;

  localparam longint SAT       = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam longint UNIT_Q30  = 64'sd1073741824;
  localparam longint COS20     = 64'sd1008987269;
  localparam longint SIN20     = 64'sd367241333;
  localparam longint MOUNT_Z   = 64'sd70 <<< 16;
  localparam longint BAND_HI   = 64'sd150 <<< 16;
  localparam longint BAND_LO   = -(64'sd50 <<< 16);
  localparam int     CYCLE_CAP = 2000000;

  typedef struct {
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
    logic               hd;
    logic               acc;
  } point_t;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [63:0] pwdata, prdata;
  logic start, busy, done;
  logic [COORD_BITS-1:0] column, row;
  logic [DEPTH_BITS-1:0] depth_sample;
  logic signed [31:0] world_x, world_y, world_z;
  logic has_depth, accepted;

  // shadow copy of the register file
  logic [63:0] shadow_regs [NREG];
  point_t pending_points [$];
  int mismatches, points_checked, points_accepted, cycle_count;
  bit idle_enable;

  depth_pixel_to_world_point_top dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .column(column), .row(row),
    .depth_sample(depth_sample), .done(done), .world_x(world_x),
    .world_y(world_y), .world_z(world_z), .has_depth(has_depth),
    .accepted(accepted)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model --
  function automatic longint clip62(longint v);
    if (v > SAT) return SAT;
    if (v < -SAT) return -SAT;
    return v;
  endfunction

  function automatic longint add_sat(longint a, longint b);
    return clip62(clip62(a) + clip62(b));
  endfunction

  // exact a*b/2^sh, round half away from zero, saturated
  function automatic longint mul_round(longint a, longint b, int sh);
    logic [127:0] p, ua, ub;
    bit neg;
    longint r;
    a = clip62(a);
    b = clip62(b);
    neg = (a < 0) != (b < 0);
    ua = 128'(a < 0 ? -a : a);
    ub = 128'(b < 0 ? -b : b);
    p = ((ua * ub) + (128'd1 << (sh - 1))) >> sh;
    r = (p > 128'(SAT)) ? SAT : longint'(p[63:0]);
    return neg ? -r : r;
  endfunction

  function automatic longint half_s(logic [31:0] u);
    return longint'($signed(u));
  endfunction

  function automatic longint half_u(logic [31:0] u);
    return longint'({32'd0, u});
  endfunction

  function automatic logic signed [31:0] to_out(longint q16);
    longint v;
    v = mul_round(q16, 1, 8);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic point_t predict_point(logic [10:0] c, logic [10:0] r,
                                           logic [15:0] raw);
    point_t pt;
    longint x, y, d, xc, yc, zc, ty, tz, px, py, pc, ps;
    longint k1, k2, k3, p1, p2, xx, yy, xy, r2, r4, r6, f, t, ux, uy;
    pt = '{default: 0};
    if (raw == 0) return pt;
    x = mul_round((longint'(c) <<< 16) - half_u(shadow_regs[REG_PP][63:32]),
                  half_u(shadow_regs[REG_IFOC][63:32]), 18);
    y = mul_round((longint'(r) <<< 16) - half_u(shadow_regs[REG_PP][31:0]),
                  half_u(shadow_regs[REG_IFOC][31:0]), 18);
    if (shadow_regs[REG_K3EN][32]) begin
      k1 = half_s(shadow_regs[REG_K12][63:32]);
      k2 = half_s(shadow_regs[REG_K12][31:0]);
      p1 = half_s(shadow_regs[REG_P12][63:32]);
      p2 = half_s(shadow_regs[REG_P12][31:0]);
      k3 = half_s(shadow_regs[REG_K3EN][31:0]);
      xx = mul_round(x, x, 30);
      yy = mul_round(y, y, 30);
      xy = mul_round(x, y, 30);
      r2 = add_sat(xx, yy);
      r4 = mul_round(r2, r2, 30);
      r6 = mul_round(r4, r2, 30);
      f = add_sat(UNIT_Q30, mul_round(k1, r2, 30));
      f = add_sat(f, mul_round(k2, r4, 30));
      f = add_sat(f, mul_round(k3, r6, 30));
      t = mul_round(p1, xy, 30);
      ux = add_sat(mul_round(x, f, 30), add_sat(t, t));
      ux = add_sat(ux, mul_round(p2, add_sat(r2, add_sat(xx, xx)), 30));
      t = mul_round(p2, xy, 30);
      uy = add_sat(mul_round(y, f, 30), add_sat(t, t));
      uy = add_sat(uy, mul_round(p1, add_sat(r2, add_sat(yy, yy)), 30));
      x = ux;
      y = uy;
    end
    d = longint'(raw) * half_u(shadow_regs[REG_DSCALE][31:0]);
    xc = mul_round(x, d, 38);
    yc = mul_round(y, d, 38);
    zc = mul_round(d, 1, 8);
    // camera axes -> world: x = Zc, y = -Xc, z = -Yc, then tilt about x
    ty = add_sat(mul_round(-xc, COS20, 30), mul_round(-yc, SIN20, 30));
    tz = add_sat(-mul_round(-xc, SIN20, 30), mul_round(-yc, COS20, 30));
    pc = half_s(shadow_regs[REG_PAN][63:32]);
    ps = half_s(shadow_regs[REG_PAN][31:0]);
    px = add_sat(mul_round(zc, pc, 30), -mul_round(ty, ps, 30));
    py = add_sat(mul_round(zc, ps, 30), mul_round(ty, pc, 30));
    px = add_sat(px, half_s(shadow_regs[REG_ORG][63:32]));
    py = add_sat(py, half_s(shadow_regs[REG_ORG][31:0]));
    tz = add_sat(tz, MOUNT_Z);
    pt.wx = to_out(px);
    pt.wy = to_out(py);
    pt.wz = to_out(tz);
    pt.hd = 1'b1;
    pt.acc = (d > 0) && (c >= LEFT_START) && (tz < BAND_HI) && (tz > BAND_LO);
    return pt;
  endfunction

  // -------------------------------------------------------------- drivers --
  task automatic write_reg(reg_idx_t idx, logic [63:0] value);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 3'b000}; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_K3EN) value &= 64'h1_FFFF_FFFF;
    else if (idx == REG_DSCALE) value &= 64'hFFFF_FFFF;
    shadow_regs[idx] = value;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // one pixel request; start stays high into the next request unless idling
  task automatic send_pixel(logic [10:0] c, logic [10:0] r, logic [15:0] raw);
    int gap;
    @(negedge clk);
    start = 1'b1; column = c; row = r; depth_sample = raw;
    do @(posedge clk); while (busy);
    pending_points.push_back(predict_point(c, r, raw));
    if (idle_enable && $urandom_range(99) < 16) begin
      gap = $urandom_range(4, 1);
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stop sending and let every prediction come back, then settle
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [15:0] rand_depth();
    case ($urandom_range(3))
      0: return 16'($urandom());
      1: return 16'($urandom_range(200, 1));
      default: return 16'($urandom_range(3000, 1));
    endcase
  endfunction

  // a plausible 640x480-ish camera with optional mild distortion and pan
  task automatic program_camera(bit distort);
    int ang;
    write_reg(REG_PP, {32'($urandom_range(400, 200)) << 16,
                       32'($urandom_range(300, 150)) << 16});
    write_reg(REG_IFOC, {32'($urandom_range(9000000, 5000000)),
                         32'($urandom_range(9000000, 5000000))});
    write_reg(REG_K12, {32'($signed($urandom_range(200000000)) - 100000000),
                        32'($signed($urandom_range(60000000)) - 30000000)});
    write_reg(REG_P12, {32'($signed($urandom_range(4000000)) - 2000000),
                        32'($signed($urandom_range(4000000)) - 2000000)});
    write_reg(REG_K3EN, {31'd0, distort,
                         32'($signed($urandom_range(20000000)) - 10000000)});
    ang = $urandom_range(3);
    case (ang)
      0: write_reg(REG_PAN, 64'h4000_0000_0000_0000);
      1: write_reg(REG_PAN, {32'd759250125, 32'd759250125});     // 45 deg
      2: write_reg(REG_PAN, {32'd0, 32'hC000_0000});             // -90 deg
      default: write_reg(REG_PAN, {32'hC000_0000, 32'd0});       // 180 deg
    endcase
    write_reg(REG_DSCALE, 64'($urandom_range(3000000, 800000)));
    write_reg(REG_ORG, {32'($signed($urandom_range(20000000)) - 10000000),
                        32'($signed($urandom_range(20000000)) - 10000000)});
  endtask

  // ---------------------------------------------------------------- tests --
  task automatic test_directed_edges();
    program_camera(1'b0);
    send_pixel(11'd320, 11'd240, 16'd0);          // no depth reading
    send_pixel(11'd0, 11'd0, 16'd1);
    send_pixel(11'd2047, 11'd2047, 16'hFFFF);
    send_pixel(11'd49, 11'd240, 16'd500);          // just left of valid columns
    send_pixel(11'd50, 11'd240, 16'd500);
    send_pixel(11'd2047, 11'd0, 16'd1000);
    send_pixel(11'd0, 11'd2047, 16'd1000);
    drain();
    write_reg(REG_K3EN, 64'h1_0000_0000 | shadow_regs[REG_K3EN]);
    send_pixel(11'd100, 11'd100, 16'd800);
    send_pixel(11'd2047, 11'd2047, 16'hFFFF);
    send_pixel(11'd0, 11'd0, 16'd0);
    drain();
    // zero depth scale: depth flagged but never accepted
    write_reg(REG_DSCALE, 64'd0);
    send_pixel(11'd300, 11'd200, 16'd1234);
    send_pixel(11'd60, 11'd10, 16'hFFFF);
    drain();
  endtask

  task automatic test_saturation();
    // every register at its extremes, distortion on
    write_reg(REG_PP, 64'd0);
    write_reg(REG_IFOC, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_K12, 64'h7FFF_FFFF_8000_0000);
    write_reg(REG_P12, 64'h8000_0000_7FFF_FFFF);
    write_reg(REG_K3EN, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PAN, 64'h7FFF_FFFF_8000_0000);
    write_reg(REG_DSCALE, 64'hFFFF_FFFF);
    write_reg(REG_ORG, 64'h7FFF_FFFF_8000_0000);
    send_pixel(11'd2047, 11'd2047, 16'hFFFF);
    send_pixel(11'd0, 11'd0, 16'hFFFF);
    send_pixel(11'd1024, 11'd1, 16'd1);
    drain();
    write_reg(REG_PP, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_ORG, 64'h8000_0000_7FFF_FFFF);
    send_pixel(11'd0, 11'd2047, 16'hFFFF);
    send_pixel(11'd2047, 11'd0, 16'h8000);
    drain();
  endtask

  task automatic test_random_phase(int n, int kind);
    case (kind)
      0: program_camera(1'b0);
      1: program_camera(1'b1);
      default: begin
        for (int i = 0; i < NREG; i++) write_reg(reg_idx_t'(IDX_W'(i)), rand64());
      end
    endcase
    for (int i = 0; i < n; i++) begin
      if (kind == 2 || $urandom_range(9) == 0)
        send_pixel(11'($urandom()), 11'($urandom()), 16'($urandom()));
      else
        send_pixel(11'($urandom_range(700)), 11'($urandom_range(520)),
                   rand_depth());
    end
    drain();
  endtask

  // -------------------------------------------------------------- checker --
  always @(posedge clk) begin
    point_t want;
    if (!rst && done) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%0d", world_x);
      end else begin
        want = pending_points.pop_front();
        points_checked++;
        if (accepted) points_accepted++;
        if (world_x !== want.wx || world_y !== want.wy || world_z !== want.wz ||
            has_depth !== want.hd || accepted !== want.acc) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0d %0d hd%0b acc%0b got %0d %0d %0d hd%0b acc%0b",
                     want.wx, want.wy, want.wz, want.hd, want.acc,
                     world_x, world_y, world_z, has_depth, accepted);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("depth_pixel_to_world_point_top_tb failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1; start = 1'b0; column = '0; row = '0; depth_sample = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    mismatches = 0; points_checked = 0; points_accepted = 0; cycle_count = 0;
    idle_enable = 1'b1;
    for (int i = 0; i < NREG; i++) shadow_regs[i] = reg_reset(reg_idx_t'(IDX_W'(i)));
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset values first: default pan and depth scale
    send_pixel(11'd100, 11'd100, 16'd500);
    drain();
    test_directed_edges();
    test_saturation();
    for (int p = 0; p < 8; p++) begin
      idle_enable = (p != 3);   // one phase back-to-back
      test_random_phase(225, (p == 6) ? 2 : p % 2);
    end

    $display("checked %0d points (%0d accepted) over reset, directed, saturating",
             points_checked, points_accepted);
    $display("and eight random register settings, with and without distortion");
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("depth_pixel_to_world_point_top_tb passed");
    end else begin
      $display("depth_pixel_to_world_point_top_tb failed");
    end
    $finish;
  end

endmodule

/* depth_pixel_to_world_point_top.f */
rtl/core/dpw_pkg.sv
rtl/core/dpw_mul.sv
rtl/core/dpw_cfg.sv
rtl/core/depth_pixel_to_world_point_top.sv
verif/depth_pixel_to_world_point_top_tb.sv
